[rtl/cobs_pkg.sv]
// ----------------------------------------------------------------------------
// cobs_pkg
// Shared constants and types of the COBS frame encoder: sizes of the cell
// chain, special byte codes and the command and status structs.
// ----------------------------------------------------------------------------
package cobs_pkg;

  // largest number of data bytes in one group
  localparam int MAX_GROUP_DATA = 254;
  // bytes per result beat
  localparam int OUT_LANES      = 8;

  // chain holds code byte, group data and up to two tail bytes
  localparam int CHAIN_CELLS = MAX_GROUP_DATA + 3;
  localparam int IDX_W       = $clog2(CHAIN_CELLS);
  localparam int CNT_W       = $clog2(CHAIN_CELLS + 1);
  localparam int LEN_W       = $clog2(MAX_GROUP_DATA + 1);
  localparam int BC_W        = 4;

  // special byte values
  localparam logic [7:0] DELIM_BYTE = 8'h00;
  localparam logic [7:0] EMPTY_CODE = 8'h01;

  // broadcast command to every cell of the chain
  typedef struct packed {
    logic             shift;
    logic             code_en;
    logic [7:0]       code;
    logic             data_en;
    logic [IDX_W-1:0] data_ptr;
    logic [7:0]       data;
    logic             tail0_en;
    logic [IDX_W-1:0] tail0_ptr;
    logic [7:0]       tail0;
    logic             tail1_en;
    logic [IDX_W-1:0] tail1_ptr;
  } cell_cmd_t;

  // status of the beat currently offered at the output
  typedef struct packed {
    logic            valid;
    logic [BC_W-1:0] count;
    logic            run_last;
    logic            frame_end;
  } out_stat_t;

endpackage

[rtl/cobs_cell.sv]
// ----------------------------------------------------------------------------
// cobs_cell
// One byte cell of the chain. Loads a byte when the broadcast write pointer
// matches its own index, and takes the byte of the cell one beat further
// down the chain while the chain drains.
// ----------------------------------------------------------------------------
module cobs_cell (
  input  logic                    clk_i,
  input  cobs_pkg::cell_cmd_t     cmd_i,
  input  logic [cobs_pkg::IDX_W-1:0] idx_i,
  input  logic [7:0]              shift_i,
  output logic [7:0]              q_o
);
  import cobs_pkg::*;

  logic [7:0] cell_q;
  logic [7:0] cell_d;

  // shift has priority, writes only happen while the chain is idle
  always_comb begin
    cell_d = cell_q;
    if (cmd_i.shift) begin
      cell_d = shift_i;
    end else if (cmd_i.code_en && (idx_i == '0)) begin
      cell_d = cmd_i.code;
    end else if (cmd_i.data_en && (idx_i == cmd_i.data_ptr)) begin
      cell_d = cmd_i.data;
    end else if (cmd_i.tail0_en && (idx_i == cmd_i.tail0_ptr)) begin
      cell_d = cmd_i.tail0;
    end else if (cmd_i.tail1_en && (idx_i == cmd_i.tail1_ptr)) begin
      cell_d = DELIM_BYTE;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign q_o = cell_q;

endmodule

[rtl/cobs_ctrl.sv]
// ----------------------------------------------------------------------------
// cobs_ctrl
// Group length tracking, group close decision and drain sequencing. Issues
// the write and shift commands for the cell chain and the status of the
// output beat.
// ----------------------------------------------------------------------------
module cobs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                frame_last_i,
  input  logic                out_ready_i,
  output cobs_pkg::cell_cmd_t cmd_o,
  output cobs_pkg::out_stat_t stat_o
);
  import cobs_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_e;

  state_e           state_q, state_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic             delim_q, delim_d;

  logic             in_acc;
  logic             out_acc;
  logic             data_nz;
  logic             full;
  logic             forced;
  logic             close;
  logic [LEN_W-1:0] new_len;
  logic [IDX_W-1:0] data_ptr;
  logic [CNT_W-1:0] tail_cnt;
  logic [CNT_W-1:0] total;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = (state_q == ST_DRAIN) && out_ready_i;

  // group bookkeeping for the incoming byte
  assign data_nz  = (data_byte_i != DELIM_BYTE);
  assign new_len  = data_nz ? (len_q + LEN_W'(1)) : len_q;
  assign full     = data_nz && (new_len == LEN_W'(MAX_GROUP_DATA));
  assign forced   = !data_nz || full;
  assign close    = forced || frame_last_i;
  assign data_ptr = IDX_W'(new_len);

  // encoded length: code byte, group bytes, then 01 00 or 00 at frame end
  always_comb begin
    tail_cnt = '0;
    if (frame_last_i) begin
      tail_cnt = forced ? CNT_W'(2) : CNT_W'(1);
    end
  end
  assign total = CNT_W'(new_len) + CNT_W'(1) + tail_cnt;

  // chain commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.shift     = out_acc;
    cmd_o.code_en   = in_acc && close;
    cmd_o.code      = 8'(new_len) + 8'd1;
    cmd_o.data_en   = in_acc && data_nz;
    cmd_o.data_ptr  = data_ptr;
    cmd_o.data      = data_byte_i;
    cmd_o.tail0_en  = in_acc && frame_last_i;
    cmd_o.tail0_ptr = data_ptr + IDX_W'(1);
    cmd_o.tail0     = forced ? EMPTY_CODE : DELIM_BYTE;
    cmd_o.tail1_en  = in_acc && frame_last_i && forced;
    cmd_o.tail1_ptr = data_ptr + IDX_W'(2);
  end

  // next state
  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    rem_d   = rem_q;
    delim_d = delim_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (close) begin
            state_d = ST_DRAIN;
            len_d   = '0;
            rem_d   = total;
            delim_d = frame_last_i;
          end else begin
            len_d = new_len;
          end
        end
      end
      ST_DRAIN: begin
        if (out_acc) begin
          if (rem_q <= CNT_W'(OUT_LANES)) begin
            state_d = ST_IDLE;
          end else begin
            rem_d = rem_q - CNT_W'(OUT_LANES);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      rem_q   <= '0;
      delim_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      delim_q <= delim_d;
    end
  end

  // output beat status
  always_comb begin
    stat_o           = '0;
    stat_o.valid     = (state_q == ST_DRAIN);
    stat_o.run_last  = (rem_q <= CNT_W'(OUT_LANES));
    stat_o.count     = stat_o.run_last ? BC_W'(rem_q) : BC_W'(OUT_LANES);
    stat_o.frame_end = delim_q && stat_o.run_last;
  end

endmodule

[rtl/cobs_frame_encoder_top.sv]
// ----------------------------------------------------------------------------
// cobs_frame_encoder_top
// COBS encoder: one payload byte per input beat, encoded stream packed eight
// bytes per output beat.
// ----------------------------------------------------------------------------
// A byte that closes no group is only stored. A byte that closes a group
// (a zero byte, the byte that fills a group to 254, or the last byte of a
// frame) is loaded and then leaves as ceil(N/8) output beats, where N is
// the number of encoded bytes (code byte, group bytes, plus 01 00 or 00 at
// frame end, so at most 257 bytes and 33 beats); the input is not ready
// while these beats drain. The pace is set by the cell chain, which holds
// the code byte, the group bytes and the tail bytes and moves eight cells
// toward the output per accepted beat. No clearing pass is needed after
// reset.
module cobs_frame_encoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       frame_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte0_o,
  output logic [7:0] out_byte1_o,
  output logic [7:0] out_byte2_o,
  output logic [7:0] out_byte3_o,
  output logic [7:0] out_byte4_o,
  output logic [7:0] out_byte5_o,
  output logic [7:0] out_byte6_o,
  output logic [7:0] out_byte7_o,
  output logic [3:0] byte_count_o,
  output logic       run_last_o,
  output logic       frame_end_o
);
  import cobs_pkg::*;

  cell_cmd_t                    cell_cmd;
  out_stat_t                    stat;
  logic [CHAIN_CELLS-1:0][7:0]  cell_q;
  logic [OUT_LANES-1:0][7:0]    lane;

  // controller
  cobs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .frame_last_i (frame_last_i),
    .out_ready_i  (out_ready_i),
    .cmd_o        (cell_cmd),
    .stat_o       (stat)
  );

  // chain of byte cells, each fed from the cell one beat further down
  for (genvar i = 0; i < CHAIN_CELLS; i++) begin : g_cell
    logic [7:0] shift_in;
    if (i + OUT_LANES < CHAIN_CELLS) begin : g_link
      assign shift_in = cell_q[i + OUT_LANES];
    end else begin : g_end
      assign shift_in = '0;
    end
    cobs_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cell_cmd),
      .idx_i   (IDX_W'(i)),
      .shift_i (shift_in),
      .q_o     (cell_q[i])
    );
  end

  // head cells form the output beat, unused lanes read zero
  always_comb begin
    for (int j = 0; j < OUT_LANES; j++) begin
      lane[j] = (stat.count > BC_W'(j)) ? cell_q[j] : 8'h00;
    end
  end

  assign out_valid_o  = stat.valid;
  assign out_byte0_o  = lane[0];
  assign out_byte1_o  = lane[1];
  assign out_byte2_o  = lane[2];
  assign out_byte3_o  = lane[3];
  assign out_byte4_o  = lane[4];
  assign out_byte5_o  = lane[5];
  assign out_byte6_o  = lane[6];
  assign out_byte7_o  = lane[7];
  assign byte_count_o = stat.count;
  assign run_last_o   = stat.run_last;
  assign frame_end_o  = stat.frame_end;

endmodule

[rtl/cobs_chk.sv]
// ----------------------------------------------------------------------------
// cobs_chk
// Port-level checks of the COBS frame encoder, bound to the top level.
// ----------------------------------------------------------------------------
module cobs_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       frame_last_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [3:0] byte_count_o,
  input logic       run_last_o,
  input logic       frame_end_o
);

  // no input beat is taken while encoded bytes are pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while output beat pending");

  // last byte of a frame always produces output on the next cycle
  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && frame_last_i) |=> out_valid_o)
    else $error("frame end produced no output");

  // only the final beat of a run may be partly filled
  a_full_beats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !run_last_o) |-> (byte_count_o == 4'd8))
    else $error("partial beat before end of run");

  // byte count within range on every offered beat
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((byte_count_o != 4'd0) && (byte_count_o <= 4'd8)))
    else $error("byte count out of range");

  // delimiter only on the last beat of a run
  a_delim_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_end_o) |-> run_last_o)
    else $error("frame end before last beat");

endmodule

bind cobs_frame_encoder_top cobs_chk u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .frame_last_i (frame_last_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .byte_count_o (byte_count_o),
  .run_last_o   (run_last_o),
  .frame_end_o  (frame_end_o)
);

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for cobs_frame_encoder_top. Payload beats are queued up
// front and played in by a clocked driver. Each accepted byte is run through a
// behavioural COBS encoder that predicts the packed words, and a clocked
// monitor checks every output beat against them in order. Both sides idle at
// random, with one long receiver stall and drain pauses before some frames.
// ----------------------------------------------------------------------------
module tb;
  import cobs_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RAND_BEATS    = 350;
  localparam int STALL_AT_BEAT = 120;
  localparam int STALL_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS   = 10;

  // one queued payload byte
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       wait_drained;
  } pay_beat_t;

  // one packed result word
  typedef struct packed {
    logic [OUT_LANES-1:0][7:0] lanes;
    logic [3:0]                count;
    logic                      run_last;
    logic                      frame_end;
  } enc_word_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_i  = 8'h00;
  logic       frame_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i  = 1'b0;
  logic [7:0] out_byte0_o, out_byte1_o, out_byte2_o, out_byte3_o;
  logic [7:0] out_byte4_o, out_byte5_o, out_byte6_o, out_byte7_o;
  logic [3:0] byte_count_o;
  logic       run_last_o;
  logic       frame_end_o;

  cobs_frame_encoder_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .frame_last_i (frame_last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte0_o  (out_byte0_o),
    .out_byte1_o  (out_byte1_o),
    .out_byte2_o  (out_byte2_o),
    .out_byte3_o  (out_byte3_o),
    .out_byte4_o  (out_byte4_o),
    .out_byte5_o  (out_byte5_o),
    .out_byte6_o  (out_byte6_o),
    .out_byte7_o  (out_byte7_o),
    .byte_count_o (byte_count_o),
    .run_last_o   (run_last_o),
    .frame_end_o  (frame_end_o)
  );

  pay_beat_t  pay_beats[$];
  enc_word_t  words_due[$];

  // encoder state mirrored by the bench
  logic [7:0] grp_store [MAX_GROUP_DATA];
  int         grp_len = 0;
  logic [7:0] enc_stream [MAX_GROUP_DATA + 4];
  int         enc_len;

  int total_beats   = 1;
  int beats_in      = 0;
  int words_checked = 0;
  int frames_queued = 0;
  int mismatches    = 0;
  int cycles        = 0;
  int stall_left    = 0;
  bit stall_done    = 1'b0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // close the open group: code byte then the stored bytes
  function void close_group();
    enc_stream[enc_len] = 8'(grp_len + 1);
    enc_len++;
    for (int i = 0; i < grp_len; i++) begin
      enc_stream[enc_len] = grp_store[i];
      enc_len++;
    end
    grp_len = 0;
  endfunction

  // encode one accepted byte and queue the packed words it yields
  function void encode_beat(input logic [7:0] b, input logic last);
    int        words;
    int        cnt;
    enc_word_t w;
    enc_len = 0;
    if (b == DELIM_BYTE) begin
      close_group();
    end else begin
      grp_store[grp_len] = b;
      grp_len++;
      if (grp_len >= MAX_GROUP_DATA) close_group();
    end
    if (last) begin
      close_group();
      enc_stream[enc_len] = DELIM_BYTE;
      enc_len++;
    end
    words = (enc_len + OUT_LANES - 1) / OUT_LANES;
    for (int k = 0; k < words; k++) begin
      w   = '0;
      cnt = enc_len - k * OUT_LANES;
      if (cnt > OUT_LANES) cnt = OUT_LANES;
      for (int j = 0; j < cnt; j++) w.lanes[j] = enc_stream[k * OUT_LANES + j];
      w.count     = 4'(cnt);
      w.run_last  = (k == words - 1);
      w.frame_end = last && (k == words - 1);
      words_due.push_back(w);
    end
  endfunction

  // idle percentage for sender or receiver in the current third of the run
  function int idle_pct(input bit rx_side);
    int phase;
    phase = beats_in * 3 / total_beats;
    if (phase == 0) return rx_side ? 62 : 23;
    if (phase == 1) return rx_side ? 23 : 62;
    return 0;
  endfunction

  task automatic add_beat(input logic [7:0] d, input logic l, input logic hold);
    pay_beat_t p;
    p.data         = d;
    p.last         = l;
    p.wait_drained = hold;
    pay_beats.push_back(p);
    if (l) frames_queued++;
  endtask

  // frame of random bytes, zeros at the given percentage
  task automatic add_frame(input int len, input int zero_pct, input logic hold);
    logic [7:0] d;
    for (int i = 0; i < len; i++) begin
      d = ($urandom_range(99) < zero_pct) ? 8'h00 : 8'($urandom_range(1, 255));
      add_beat(d, i == len - 1, hold && i == 0);
    end
  endtask

  // driver: offer queued bytes, predict on each accepted beat
  always @(posedge clk_i) begin
    logic      nxt_valid;
    pay_beat_t p;
    if (rst_ni) begin
      nxt_valid = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        encode_beat(data_byte_i, frame_last_i);
        beats_in++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pay_beats.size() > 0) begin
        if (pay_beats[0].wait_drained && words_due.size() > 0) begin
          nxt_valid = 1'b0;
        end else if ($urandom_range(99) >= idle_pct(1'b0)) begin
          p = pay_beats.pop_front();
          data_byte_i  <= p.data;
          frame_last_i <= p.last;
          nxt_valid    = 1'b1;
        end
      end
      in_valid_i <= nxt_valid;
    end
  end

  // monitor: check each output beat against the oldest predicted word
  always @(posedge clk_i) begin
    enc_word_t got;
    enc_word_t exp_w;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.lanes     = {out_byte7_o, out_byte6_o, out_byte5_o, out_byte4_o,
                         out_byte3_o, out_byte2_o, out_byte1_o, out_byte0_o};
        got.count     = byte_count_o;
        got.run_last  = run_last_o;
        got.frame_end = frame_end_o;
        if (words_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] unexpected word: lanes=%h cnt=%0d run_last=%b frame_end=%b",
                     $realtime, got.lanes, got.count, got.run_last, got.frame_end);
        end else begin
          exp_w = words_due.pop_front();
          words_checked++;
          if (got.lanes !== exp_w.lanes || got.count !== exp_w.count ||
              got.run_last !== exp_w.run_last || got.frame_end !== exp_w.frame_end) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("[%0t] word %0d exp: lanes=%h cnt=%0d run_last=%b frame_end=%b",
                       $realtime, words_checked, exp_w.lanes, exp_w.count,
                       exp_w.run_last, exp_w.frame_end);
              $display("[%0t] word %0d got: lanes=%h cnt=%0d run_last=%b frame_end=%b",
                       $realtime, words_checked, got.lanes, got.count,
                       got.run_last, got.frame_end);
            end
          end
        end
      end
      // one long receiver hold-off so the block backs up into the input
      if (!stall_done && beats_in >= STALL_AT_BEAT) begin
        stall_left = STALL_CYCLES;
        stall_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= idle_pct(1'b1));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("cobs_frame_encoder_top verification failed");
      $finish;
    end
  end

  // stimulus, reset and end of run
  initial begin
    int rand_beats;
    int nframe;
    int sel;
    int len;

    // directed: single zero, single 0xff, mixed zeros, two-word group, zero pair
    add_beat(8'h00, 1'b1, 1'b0);
    add_beat(8'hFF, 1'b1, 1'b0);
    add_beat(8'h01, 1'b0, 1'b1);
    add_beat(8'h80, 1'b0, 1'b0);
    add_beat(8'h00, 1'b0, 1'b0);
    add_beat(8'h7F, 1'b0, 1'b0);
    add_beat(8'h00, 1'b0, 1'b0);
    add_beat(8'h00, 1'b0, 1'b0);
    add_beat(8'h55, 1'b1, 1'b0);
    add_beat(8'hAA, 1'b0, 1'b0);
    add_beat(8'h55, 1'b0, 1'b0);
    add_beat(8'hFF, 1'b0, 1'b0);
    add_beat(8'h01, 1'b0, 1'b0);
    add_beat(8'h80, 1'b0, 1'b0);
    add_beat(8'h7F, 1'b0, 1'b0);
    add_beat(8'hFE, 1'b0, 1'b0);
    add_beat(8'h02, 1'b0, 1'b0);
    add_beat(8'h40, 1'b0, 1'b0);
    add_beat(8'h00, 1'b1, 1'b0);
    add_beat(8'h00, 1'b0, 1'b0);
    add_beat(8'h00, 1'b1, 1'b0);

    // random frames, one of them filling a whole group
    rand_beats = 0;
    nframe     = 0;
    while (rand_beats < RAND_BEATS) begin
      if (nframe == 3) begin
        // group fills exactly on the final byte
        add_frame(MAX_GROUP_DATA, 0, 1'b0);
        rand_beats += MAX_GROUP_DATA;
      end else begin
        sel = $urandom_range(99);
        if (sel < 60) len = $urandom_range(1, 12);
        else if (sel < 92) len = $urandom_range(13, 48);
        else len = $urandom_range(49, 120);
        if ($urandom_range(9) == 0) add_frame(len, $urandom_range(50, 100), 1'b0);
        else add_frame(len, $urandom_range(0, 40), nframe == 6);
        rand_beats += len;
      end
      nframe++;
    end
    total_beats = pay_beats.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beats_in < total_beats) @(posedge clk_i);
    while (words_due.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    mismatches += words_due.size();
    $display("run covered %0d frames, %0d payload beats and %0d encoded words",
             frames_queued, beats_in, words_checked);
    $display("including full-group closes, zero and fill on the final byte; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("cobs_frame_encoder_top verification clean");
    end else begin
      $display("cobs_frame_encoder_top verification failed");
    end
    $finish;
  end

endmodule

[cobs_frame_encoder_top.f]
rtl/cobs_pkg.sv
rtl/cobs_cell.sv
rtl/cobs_ctrl.sv
rtl/cobs_frame_encoder_top.sv
rtl/cobs_chk.sv
verif/tb.sv
